### rtl/srfu_pkg.sv
// Shared types, operation codes and helpers for the shift/rotate/flags unit.
// No dependencies; every other file of the block imports it.
package srfu_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned HalfWidth  = 32;
   localparam int unsigned CountWidth = 6;
   localparam int unsigned KindWidth  = 3;
   localparam int unsigned FlagWidth  = 5;

   localparam logic [KindWidth-1:0] KIND_SHL  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_SHR  = 3'd1;
   localparam logic [KindWidth-1:0] KIND_SAR  = 3'd2;
   localparam logic [KindWidth-1:0] KIND_ROL  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_ROR  = 3'd4;
   localparam logic [KindWidth-1:0] KIND_SHLD = 3'd5;
   localparam logic [KindWidth-1:0] KIND_SHRD = 3'd6;

   localparam int unsigned FLAG_CF = 0;
   localparam int unsigned FLAG_PF = 1;
   localparam int unsigned FLAG_ZF = 2;
   localparam int unsigned FLAG_SF = 3;
   localparam int unsigned FLAG_OF = 4;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic                  wide;
      logic [DataWidth-1:0]  value;
      logic [DataWidth-1:0]  fill;
      logic [CountWidth-1:0] count;
      logic [FlagWidth-1:0]  flags_in;
   } request_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 cf_left;
      logic                 cf_right;
   } funnel_out_type;

   // 32-bit mode masks the count to 5 bits
   function automatic logic [CountWidth-1:0] eff_count(input logic wide,
                                                      input logic [CountWidth-1:0] count);
      eff_count = wide ? count : {1'b0, count[CountWidth-2:0]};
   endfunction

endpackage

### rtl/srfu_funnel.sv
// Funnel shifter: one right shift of a double-width word covers every operation.
// Depends on srfu_pkg.
module srfu_funnel (
   input  srfu_pkg::request_type    req,
   output srfu_pkg::funnel_out_type fo
);
   import srfu_pkg::*;

   logic [CountWidth-1:0]  c;
   logic                   left_op;
   logic [DataWidth-1:0]   hi;
   logic [DataWidth-1:0]   lo;
   logic [DataWidth-1:0]   v;
   logic [DataWidth-1:0]   f;
   logic [DataWidth-1:0]   sign_fill;
   logic [2*DataWidth-1:0] x;
   logic [2*DataWidth:0]   y;
   logic [2*DataWidth:0]   z;
   logic [CountWidth-1:0]  shamt;

   always_comb begin
      c         = eff_count(req.wide, req.count);
      v         = req.wide ? req.value : {{HalfWidth{1'b0}}, req.value[HalfWidth-1:0]};
      f         = req.wide ? req.fill  : {{HalfWidth{1'b0}}, req.fill[HalfWidth-1:0]};
      sign_fill = req.wide ? {DataWidth{req.value[DataWidth-1]}}
                           : {{HalfWidth{1'b0}}, {HalfWidth{req.value[HalfWidth-1]}}};
      left_op   = 1'b0;
      hi        = '0;
      lo        = v;
      case (req.kind)
         KIND_SHL: begin
            hi = v; lo = '0; left_op = 1'b1;
         end
         KIND_SHR: begin
            hi = '0; lo = v;
         end
         KIND_SAR: begin
            hi = sign_fill; lo = v;
         end
         KIND_ROL: begin
            hi = v; lo = v; left_op = 1'b1;
         end
         KIND_ROR: begin
            hi = v; lo = v;
         end
         KIND_SHLD: begin
            hi = v; lo = f; left_op = 1'b1;
         end
         KIND_SHRD: begin
            hi = f; lo = v;
         end
         default: begin
            hi = '0; lo = v;
         end
      endcase

      if (req.wide) begin
         x = {hi, lo};
      end else begin
         x = {{DataWidth{1'b0}}, hi[HalfWidth-1:0], lo[HalfWidth-1:0]};
      end

      if (left_op) begin
         shamt = req.wide ? CountWidth'(7'd64 - {1'b0, c}) : CountWidth'(6'd32 - c);
      end else begin
         shamt = c;
      end

      // guard bit below the window catches the last bit shifted out to the right
      y = {x, 1'b0};
      z = y >> shamt;

      fo.result   = req.wide ? z[DataWidth:1] : {{HalfWidth{1'b0}}, z[HalfWidth:1]};
      fo.cf_left  = req.wide ? z[DataWidth+1] : z[HalfWidth+1];
      fo.cf_right = z[0];
   end

endmodule

### rtl/srfu_flags.sv
// Flag generation and bypass (zero count or unused kind) for the shift/rotate unit.
// Depends on srfu_pkg and the funnel shifter output.
module srfu_flags (
   input  srfu_pkg::request_type                    req,
   input  srfu_pkg::funnel_out_type                 fo,
   output logic [srfu_pkg::DataWidth-1:0]           result,
   output logic [srfu_pkg::FlagWidth-1:0]           flags_out
);
   import srfu_pkg::*;

   logic [CountWidth-1:0] c;
   logic                  count_one;
   logic                  bypass;
   logic                  rotate;
   logic                  cf;
   logic                  of;
   logic                  top_r;
   logic                  next_r;
   logic                  top_v;
   logic [DataWidth-1:0]  r;

   always_comb begin
      c         = eff_count(req.wide, req.count);
      count_one = (c == CountWidth'(1));
      bypass    = (c == '0) || (req.kind > KIND_SHRD);
      r         = fo.result;
      top_r     = req.wide ? r[DataWidth-1] : r[HalfWidth-1];
      next_r    = req.wide ? r[DataWidth-2] : r[HalfWidth-2];
      top_v     = req.wide ? req.value[DataWidth-1] : req.value[HalfWidth-1];
      rotate    = 1'b0;
      cf        = fo.cf_right;
      of        = 1'b0;
      case (req.kind)
         KIND_SHL, KIND_SHLD: begin
            cf = fo.cf_left;
            of = top_r ^ fo.cf_left;
         end
         KIND_SHR, KIND_SHRD: begin
            cf = fo.cf_right;
            of = count_one & (top_r ^ top_v);
         end
         KIND_SAR: begin
            cf = fo.cf_right;
            of = 1'b0;
         end
         KIND_ROL: begin
            rotate = 1'b1;
            cf     = r[0];
            of     = count_one & (top_r ^ r[0]);
         end
         KIND_ROR: begin
            rotate = 1'b1;
            cf     = top_r;
            of     = count_one & (top_r ^ next_r);
         end
         default: begin
            cf = fo.cf_right;
            of = 1'b0;
         end
      endcase

      if (bypass) begin
         result    = req.wide ? req.value : {{HalfWidth{1'b0}}, req.value[HalfWidth-1:0]};
         flags_out = req.flags_in;
      end else begin
         result             = r;
         flags_out[FLAG_CF] = cf;
         flags_out[FLAG_OF] = of;
         if (rotate) begin
            flags_out[FLAG_PF] = req.flags_in[FLAG_PF];
            flags_out[FLAG_ZF] = req.flags_in[FLAG_ZF];
            flags_out[FLAG_SF] = req.flags_in[FLAG_SF];
         end else begin
            flags_out[FLAG_PF] = ~^r[7:0];
            flags_out[FLAG_ZF] = (r == '0);
            flags_out[FLAG_SF] = top_r;
         end
      end
   end

endmodule

### rtl/x86_shift_rotate_flags_unit_top.sv
// Top level of the x86 shift/rotate unit with flags: input register, funnel, flags, output.
// Depends on srfu_pkg, srfu_funnel and srfu_flags.
//
//   channel   direction  handshake             payload
//   request   in         start (busy always 0) req_kind, req_wide, req_value, req_fill,
//                                              req_count, req_flags_in
//   response  out        rsp_valid strobe      rsp_result, rsp_flags_out
//
// One request per cycle.
// Latency is set by the input register and the result register around one
// funnel shifter pass. Synchronous reset clears both valid bits.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
module x86_shift_rotate_flags_unit_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [srfu_pkg::KindWidth-1:0]       req_kind,
   input  logic                                 req_wide,
   input  logic [srfu_pkg::DataWidth-1:0]       req_value,
   input  logic [srfu_pkg::DataWidth-1:0]       req_fill,
   input  logic [srfu_pkg::CountWidth-1:0]      req_count,
   input  logic [srfu_pkg::FlagWidth-1:0]       req_flags_in,
   output logic                                 rsp_valid,
   output logic [srfu_pkg::DataWidth-1:0]       rsp_result,
   output logic [srfu_pkg::FlagWidth-1:0]       rsp_flags_out
);
   import srfu_pkg::*;

   request_type           req_ff;
   request_type           req_in;
   logic                  stage_valid_ff;
   funnel_out_type        fo;
   logic [DataWidth-1:0]  result_in;
   logic [FlagWidth-1:0]  flags_in;
   logic [DataWidth-1:0]  result_ff;
   logic [FlagWidth-1:0]  flags_ff;
   logic                  rsp_valid_ff;

   assign busy = 1'b0;

   always_comb begin
      req_in.kind     = req_kind;
      req_in.wide     = req_wide;
      req_in.value    = req_value;
      req_in.fill     = req_fill;
      req_in.count    = req_count;
      req_in.flags_in = req_flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= start && !busy;
         rsp_valid_ff   <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_in;
      end
      if (stage_valid_ff) begin
         result_ff <= result_in;
         flags_ff  <= flags_in;
      end
   end

   srfu_funnel u_funnel (
      .req (req_ff),
      .fo  (fo)
   );

   srfu_flags u_flags (
      .req       (req_ff),
      .fo        (fo),
      .result    (result_in),
      .flags_out (flags_in)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = result_ff;
   assign rsp_flags_out = flags_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |=> !rsp_valid_ff)
      else $error("response without request");

   a_narrow_zero_ext: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !req_ff.wide |=> rsp_result[DataWidth-1:HalfWidth] == '0)
      else $error("32-bit result not zero-extended");

   a_rotate_keeps: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && (req_ff.kind == KIND_ROL || req_ff.kind == KIND_ROR)
      |=> rsp_flags_out[FLAG_SF:FLAG_PF] == $past(req_ff.flags_in[FLAG_SF:FLAG_PF]))
      else $error("rotate changed PF/ZF/SF");

   a_sar_of: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && req_ff.kind == KIND_SAR && eff_count(req_ff.wide, req_ff.count) != '0
      |=> !rsp_flags_out[FLAG_OF])
      else $error("SAR set OF");

endmodule

### test/x86_shift_rotate_flags_unit_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for x86_shift_rotate_flags_unit_top: directed and random requests,
// with a local model of the shift/rotate result and flags. Depends on srfu_pkg and the DUT.
module x86_shift_rotate_flags_unit_top_test;
   import srfu_pkg::*;

   localparam logic [KindWidth-1:0] KIND_UNUSED = 3'd7;
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 10;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic [FlagWidth-1:0] flags;
   } shift_result_type;

   class shift_scoreboard;
      shift_result_type expected_results[$];
      int unsigned      errors;

      function automatic shift_result_type compute_shift(logic [KindWidth-1:0] kind, logic wide,
            logic [DataWidth-1:0] value, logic [DataWidth-1:0] fill,
            logic [CountWidth-1:0] count, logic [FlagWidth-1:0] flags_in);
         shift_result_type     res;
         int unsigned          w;
         int unsigned          top;
         int unsigned          c;
         logic [DataWidth-1:0] mask;
         logic [DataWidth-1:0] v;
         logic [DataWidth-1:0] f;
         logic [DataWidth-1:0] r;
         logic                 cf;
         logic                 of;
         logic                 rotate;
         logic [FlagWidth-1:0] fl;
         w      = wide ? 64 : 32;
         top    = w - 1;
         mask   = wide ? {DataWidth{1'b1}} : 64'h0000_0000_ffff_ffff;
         v      = value & mask;
         f      = fill & mask;
         c      = wide ? count : count[CountWidth-2:0];
         rotate = 1'b0;
         cf     = 1'b0;
         of     = 1'b0;
         r      = v;
         if (c == 0 || kind == KIND_UNUSED) begin
            res.result = v;
            res.flags  = flags_in;
            return res;
         end
         case (kind)
            KIND_SHL: begin
               cf = v[w - c];
               r  = (v << c) & mask;
               of = r[top] ^ cf;
            end
            KIND_SHR: begin
               cf = v[c - 1];
               r  = v >> c;
               of = (c == 1) ? (r[top] ^ v[top]) : 1'b0;
            end
            KIND_SAR: begin
               cf = v[c - 1];
               r  = v >> c;
               if (v[top]) r = r | ((mask << (w - c)) & mask);
            end
            KIND_ROL: begin
               r      = ((v << c) | (v >> (w - c))) & mask;
               cf     = r[0];
               of     = (c == 1) ? (r[top] ^ cf) : 1'b0;
               rotate = 1'b1;
            end
            KIND_ROR: begin
               r      = ((v >> c) | (v << (w - c))) & mask;
               cf     = r[top];
               of     = (c == 1) ? (cf ^ r[top - 1]) : 1'b0;
               rotate = 1'b1;
            end
            KIND_SHLD: begin
               cf = v[w - c];
               r  = ((v << c) | (f >> (w - c))) & mask;
               of = r[top] ^ cf;
            end
            default: begin
               cf = v[c - 1];
               r  = ((v >> c) | (f << (w - c))) & mask;
               of = (c == 1) ? (r[top] ^ v[top]) : 1'b0;
            end
         endcase
         fl = '0;
         if (rotate) begin
            fl[FLAG_PF] = flags_in[FLAG_PF];
            fl[FLAG_ZF] = flags_in[FLAG_ZF];
            fl[FLAG_SF] = flags_in[FLAG_SF];
         end else begin
            fl[FLAG_PF] = ~^r[7:0];
            fl[FLAG_ZF] = (r == '0);
            fl[FLAG_SF] = r[top];
         end
         fl[FLAG_CF] = cf;
         fl[FLAG_OF] = of;
         res.result  = r;
         res.flags   = fl;
         return res;
      endfunction

      function void note_request(logic [KindWidth-1:0] kind, logic wide,
            logic [DataWidth-1:0] value, logic [DataWidth-1:0] fill,
            logic [CountWidth-1:0] count, logic [FlagWidth-1:0] flags_in);
         expected_results.push_back(compute_shift(kind, wide, value, fill, count, flags_in));
      endfunction

      function void check_response(logic [DataWidth-1:0] result, logic [FlagWidth-1:0] flags);
         shift_result_type exp_res;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected response result=%h flags=%b", $time, result, flags);
            return;
         end
         exp_res = expected_results.pop_front();
         if (result !== exp_res.result) begin
            errors++;
            $display("%0t: result mismatch expected=%h actual=%h",
                     $time, exp_res.result, result);
         end
         if (flags !== exp_res.flags) begin
            errors++;
            $display("%0t: flags mismatch expected=%b actual=%b",
                     $time, exp_res.flags, flags);
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [KindWidth-1:0]  req_kind;
   logic                  req_wide;
   logic [DataWidth-1:0]  req_value;
   logic [DataWidth-1:0]  req_fill;
   logic [CountWidth-1:0] req_count;
   logic [FlagWidth-1:0]  req_flags_in;
   logic                  rsp_valid;
   logic [DataWidth-1:0]  rsp_result;
   logic [FlagWidth-1:0]  rsp_flags_out;

   shift_scoreboard sb = new();
   bit              gaps_on;
   int unsigned     stall_cycles;

   x86_shift_rotate_flags_unit_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_wide      (req_wide),
      .req_value     (req_value),
      .req_fill      (req_fill),
      .req_count     (req_count),
      .req_flags_in  (req_flags_in),
      .rsp_valid     (rsp_valid),
      .rsp_result    (rsp_result),
      .rsp_flags_out (rsp_flags_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_kind, req_wide, req_value, req_fill, req_count, req_flags_in);
         if (rsp_valid)
            sb.check_response(rsp_result, rsp_flags_out);
         if ((start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t: timeout", $time);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   task automatic send_request(input logic [KindWidth-1:0] kind, input logic wide,
         input logic [DataWidth-1:0] value, input logic [DataWidth-1:0] fill,
         input logic [CountWidth-1:0] count, input logic [FlagWidth-1:0] flags_in);
      req_kind     <= kind;
      req_wide     <= wide;
      req_value    <= value;
      req_fill     <= fill;
      req_count    <= count;
      req_flags_in <= flags_in;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gaps_on && $urandom_range(99) < 20) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [DataWidth-1:0] random_operand();
      case ($urandom_range(9))
         0: return {DataWidth{1'b1}};
         1: return '0;
         2: return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [KindWidth-1:0]  kind;
      logic                  wide;
      logic [CountWidth-1:0] count;
      reset        = 1'b1;
      start        = 1'b0;
      req_kind     = KIND_SHL;
      req_wide     = 1'b0;
      req_value    = '0;
      req_fill     = '0;
      req_count    = '0;
      req_flags_in = '0;
      stall_cycles = 0;
      gaps_on      = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // count of one on every kind, both widths
      for (int k = 0; k < 8; k++)
         send_request(KindWidth'(k), 1'b1, 64'h8000_0000_0000_0001, {DataWidth{1'b1}},
                      6'd1, 5'h1f);
      for (int k = 0; k < 7; k++)
         send_request(KindWidth'(k), 1'b0, 64'hdead_beef_8000_0001, 64'h1234_5678_9abc_def0,
                      6'd1, 5'h00);
      send_request(KIND_SHL,  1'b1, {DataWidth{1'b1}}, {DataWidth{1'b1}}, 6'd63, 5'h00);
      send_request(KIND_SHR,  1'b1, '0, {DataWidth{1'b1}}, 6'd63, 5'h1f);
      send_request(KIND_SAR,  1'b0, 64'hffff_ffff_8000_0000, '0, 6'd31, 5'h00);
      send_request(KIND_ROR,  1'b0, 64'h0123_4567_89ab_cdef, '0, 6'd32, 5'h15);
      send_request(KIND_ROL,  1'b1, 64'h0123_4567_89ab_cdef, '0, 6'd0, 5'h0a);
      send_request(KIND_SHRD, 1'b1, {DataWidth{1'b1}}, '0, 6'd63, 5'h00);
      send_request(KIND_SHLD, 1'b0, 64'h0000_0000_4000_0000, 64'hffff_ffff_ffff_ffff,
                   6'd33, 5'h00);
      send_request(KIND_ROR,  1'b1, 64'h8000_0000_0000_0000, '0, 6'd63, 5'h1f);
      drain();

      for (int i = 0; i < 1000; i++) begin
         gaps_on = !(i >= 300 && i < 500);
         kind = ($urandom_range(19) == 0) ? KIND_UNUSED : KindWidth'($urandom_range(6));
         wide = 1'($urandom_range(1));
         case ($urandom_range(9))
            0, 1, 2: count = 6'd1;
            3:       count = wide ? 6'd63 : 6'd31;
            4:       count = 6'd0;
            default: count = CountWidth'($urandom_range(63));
         endcase
         send_request(kind, wide, random_operand(), random_operand(), count,
                      FlagWidth'($urandom_range(31)));
         if (i == 650) drain();
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### x86_shift_rotate_flags_unit_top.f
rtl/srfu_pkg.sv
rtl/srfu_funnel.sv
rtl/srfu_flags.sv
rtl/x86_shift_rotate_flags_unit_top.sv
test/x86_shift_rotate_flags_unit_top_test.sv
